@@ rtl/ttvc_pkg.sv @@
// ttvc_pkg: types, codes and constant tables for the typed token value checker.
// Used by ttvc_step, typed_token_value_checker and ttvc_checker. No dependencies.
`timescale 1ns / 1ps

package ttvc_pkg;

  localparam int MAX_TOKEN_BYTES_DEF = 64;
  localparam int NUM_SPELL = 6;

  typedef enum logic [1:0] {
    KIND_SIGNED   = 2'd0,
    KIND_UNSIGNED = 2'd1,
    KIND_BOOL     = 2'd2,
    KIND_TEXT     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    RSN_OK      = 3'd0,
    RSN_INVALID = 3'd1,
    RSN_NUL     = 3'd2,
    RSN_BELOW   = 3'd3,
    RSN_ABOVE   = 3'd4,
    RSN_SHORT   = 3'd5,
    RSN_LONG    = 3'd6
  } reason_t;

  typedef enum logic [2:0] {
    CFG_ARG_KIND  = 3'd0,
    CFG_MIN_VALUE = 3'd1,
    CFG_MAX_VALUE = 3'd2,
    CFG_MIN_LEN   = 3'd3,
    CFG_MAX_LEN   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [32:0] min_value;
    logic [32:0] max_value;
    logic [6:0]  min_len;
    logic [6:0]  max_len;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  pos;
    logic [31:0] acc;
    logic        neg;
    reason_t     pend_reason;
    logic [6:0]  pend_offset;
    logic [5:0]  spell;
    logic        overlong;
  } tok_state_t;

  typedef struct packed {
    reason_t     reason;
    logic [32:0] value;
    logic [6:0]  offset;
  } verdict_t;

  localparam logic [32:0] INT_POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [32:0] INT_NEG_LIMIT = 33'h0_8000_0000;
  localparam logic [32:0] UINT_LIMIT    = 33'h0_FFFF_FFFF;

  localparam logic [32:0] MIN_VALUE_RST = 33'h1_8000_0000;
  localparam logic [32:0] MAX_VALUE_RST = 33'h0_FFFF_FFFF;
  localparam logic [6:0]  MIN_LEN_RST   = 7'd0;
  localparam logic [6:0]  MAX_LEN_RST   = 7'd64;

  // on, true, 1 (value 1), then off, false, 0 (value 0)
  localparam logic [7:0] SPELL_CHAR [NUM_SPELL][8] = '{
    '{"o", "n", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"t", "r", "u",  "e",  8'h0, 8'h0, 8'h0, 8'h0},
    '{"1", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"o", "f", "f",  8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"f", "a", "l",  "s",  "e",  8'h0, 8'h0, 8'h0},
    '{"0", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0}
  };
  localparam logic [2:0] SPELL_LEN [NUM_SPELL] = '{3'd2, 3'd4, 3'd1, 3'd3, 3'd5, 3'd1};

  localparam tok_state_t TOKEN_CLEAR = '{
    pos:         7'd0,
    acc:         32'd0,
    neg:         1'b0,
    pend_reason: RSN_OK,
    pend_offset: 7'd0,
    spell:       6'h3F,
    overlong:    1'b0
  };

endpackage

@@ rtl/ttvc_step.sv @@
// ttvc_step: per-byte token update and end-of-token verdict, purely combinational.
// Depends on ttvc_pkg.
`timescale 1ns / 1ps

module ttvc_step import ttvc_pkg::*; #(
  parameter int MAX_TOKEN_BYTES = MAX_TOKEN_BYTES_DEF
) (
  input  cfg_t       cfg,
  input  tok_state_t st,
  input  logic [7:0] token_byte,
  input  logic       last_byte,
  input  logic       empty_token,
  output tok_state_t st_post,
  output logic       produce,
  output verdict_t   verdict
);

  localparam int         POS_CAP_I = (MAX_TOKEN_BYTES < 127) ? MAX_TOKEN_BYTES : 127;
  localparam logic [6:0] POS_CAP   = 7'(POS_CAP_I);

  logic [7:0]  lw;
  logic        is_digit;
  logic [35:0] dig_sum;
  logic        take_digit;
  logic [32:0] limit;
  reason_t     over_rsn;
  logic [6:0]  idx;
  logic [6:0]  count;
  logic [32:0] sval;

  assign idx      = st.pos;
  assign lw       = (token_byte >= "A" && token_byte <= "Z") ? (token_byte | 8'h20) : token_byte;
  assign is_digit = (token_byte >= "0") && (token_byte <= "9");
  // acc * 10 + digit as two shifted copies
  assign dig_sum  = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0}
                  + {32'd0, token_byte[3:0] - 4'd0};
  assign produce  = empty_token | last_byte;

  always_comb begin
    st_post    = st;
    take_digit = 1'b0;
    limit      = UINT_LIMIT;
    over_rsn   = RSN_ABOVE;
    if (!empty_token) begin
      if (st.pos >= POS_CAP) begin
        st_post.overlong = 1'b1;
      end else begin
        st_post.pos = st.pos + 7'd1;
      end
      for (int s = 0; s < NUM_SPELL; s++) begin
        if (idx >= {4'd0, SPELL_LEN[s]} || lw != SPELL_CHAR[s][idx[2:0]]) begin
          st_post.spell[s] = 1'b0;
        end
      end
      if (st.pend_reason == RSN_OK) begin
        unique case (cfg.kind)
          KIND_SIGNED: begin
            limit    = st.neg ? INT_NEG_LIMIT : INT_POS_LIMIT;
            over_rsn = st.neg ? RSN_BELOW : RSN_ABOVE;
            if (idx == 7'd0 && token_byte == "+") begin
              st_post.pend_reason = RSN_INVALID;
              st_post.pend_offset = 7'd0;
            end else if (idx == 7'd0 && token_byte == "-") begin
              st_post.neg = 1'b1;
            end else begin
              take_digit = 1'b1;
            end
          end
          KIND_UNSIGNED: begin
            take_digit = 1'b1;
          end
          default: begin
            if (token_byte == 8'h00) begin
              st_post.pend_reason = RSN_NUL;
              st_post.pend_offset = idx;
            end
          end
        endcase
        if (take_digit) begin
          priority if (token_byte == 8'h00) begin
            st_post.pend_reason = RSN_NUL;
            st_post.pend_offset = idx;
          end else if (!is_digit) begin
            st_post.pend_reason = RSN_INVALID;
            st_post.pend_offset = idx;
          end else if (dig_sum > {3'b000, limit}) begin
            st_post.pend_reason = over_rsn;
            st_post.pend_offset = idx;
          end else begin
            st_post.acc = dig_sum[31:0];
          end
        end
      end
    end
  end

  assign count = st_post.pos;
  assign sval  = st_post.neg ? (33'd0 - {1'b0, st_post.acc}) : {1'b0, st_post.acc};

  always_comb begin
    verdict.reason = RSN_OK;
    verdict.value  = 33'd0;
    verdict.offset = 7'd0;
    if (st_post.pend_reason != RSN_OK) begin
      verdict.reason = st_post.pend_reason;
      verdict.offset = st_post.pend_offset;
      if (cfg.kind == KIND_TEXT) begin
        verdict.value = {26'd0, count};
      end
    end else begin
      unique case (cfg.kind)
        KIND_SIGNED, KIND_UNSIGNED: begin
          if (count == 7'd0 || (cfg.kind == KIND_SIGNED && st_post.neg && count == 7'd1)) begin
            verdict.reason = RSN_INVALID;
          end else begin
            verdict.value = (cfg.kind == KIND_SIGNED) ? sval : {1'b0, st_post.acc};
            if ($signed(verdict.value) < $signed(cfg.min_value)) begin
              verdict.reason = RSN_BELOW;
            end else if ($signed(verdict.value) > $signed(cfg.max_value)) begin
              verdict.reason = RSN_ABOVE;
            end
          end
        end
        KIND_BOOL: begin
          verdict.reason = RSN_INVALID;
          // scan downward so the first spelling in table order wins
          for (int s = NUM_SPELL - 1; s >= 0; s--) begin
            if (st_post.spell[s] && count == {4'd0, SPELL_LEN[s]}) begin
              verdict.reason = RSN_OK;
              verdict.value  = (s < 3) ? 33'd1 : 33'd0;
            end
          end
        end
        default: begin
          verdict.value = {26'd0, count};
          if (!st_post.overlong && count < cfg.min_len) begin
            verdict.reason = RSN_SHORT;
          end else if (st_post.overlong || count > cfg.max_len) begin
            verdict.reason = RSN_LONG;
          end
        end
      endcase
      if (verdict.reason != RSN_OK && cfg.kind != KIND_TEXT) begin
        verdict.value = 33'd0;
      end
    end
  end

endmodule

@@ rtl/typed_token_value_checker.sv @@
// Path (2-stage): input register, then result register; a token's verdict enters the
// result register once it has room. Throughput: one byte per cycle while in_stall is low;
// token state updates once per byte; the output register frees a slot when out_stall is low.
// Reset (rst_n low, synchronous): pipeline empty, token state cleared, registers to defaults.
// Top level: input register, ttvc_step datapath, result register. Depends on ttvc_pkg and ttvc_step.
`timescale 1ns / 1ps

module typed_token_value_checker import ttvc_pkg::*; #(
  parameter int MAX_TOKEN_BYTES = MAX_TOKEN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [32:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_token_byte,
  input  logic        in_last_byte,
  input  logic        in_empty_token,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_reason,
  output logic [32:0] out_value_out,
  output logic [6:0]  out_error_offset
);

  cfg_t       cfg_r;
  tok_state_t tok_r, tok_nxt, tok_post;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r, s1_empty_r;
  logic       produce, s1_go, in_take, out_load, out_room;
  verdict_t   verdict, out_r;
  logic       out_valid_r, out_valid_nxt;

  ttvc_step #(.MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)) u_step (
    .cfg         (cfg_r),
    .st          (tok_r),
    .token_byte  (s1_byte_r),
    .last_byte   (s1_last_r),
    .empty_token (s1_empty_r),
    .st_post     (tok_post),
    .produce     (produce),
    .verdict     (verdict)
  );

  assign out_room      = !out_valid_r || !out_stall;
  assign s1_go         = s1_valid_r && (!produce || out_room);
  assign in_stall      = s1_valid_r && !s1_go;
  assign in_take       = in_valid && !in_stall;
  assign out_load      = s1_go && produce;
  assign s1_valid_nxt  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_comb begin
    tok_nxt = tok_r;
    if (s1_go) begin
      tok_nxt = produce ? TOKEN_CLEAR : tok_post;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tok_r       <= TOKEN_CLEAR;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      tok_r       <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_token_byte;
      s1_last_r  <= in_last_byte;
      s1_empty_r <= in_empty_token;
    end
    if (out_load) begin
      out_r <= verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind      <= KIND_SIGNED;
      cfg_r.min_value <= MIN_VALUE_RST;
      cfg_r.max_value <= MAX_VALUE_RST;
      cfg_r.min_len   <= MIN_LEN_RST;
      cfg_r.max_len   <= MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ARG_KIND:  cfg_r.kind      <= kind_t'(cfg_wdata[1:0]);
        CFG_MIN_VALUE: cfg_r.min_value <= cfg_wdata;
        CFG_MAX_VALUE: cfg_r.max_value <= cfg_wdata;
        CFG_MIN_LEN:   cfg_r.min_len   <= cfg_wdata[6:0];
        CFG_MAX_LEN:   cfg_r.max_len   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reason       = out_r.reason;
  assign out_value_out    = out_r.value;
  assign out_error_offset = out_r.offset;

endmodule

@@ rtl/ttvc_checker.sv @@
// ttvc_checker: port-level assertions for typed_token_value_checker, bound to the top level.
// Depends on ttvc_pkg.
`timescale 1ns / 1ps

module ttvc_checker import ttvc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic [2:0]  cfg_index,
  input logic [32:0] cfg_wdata,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_token_byte,
  input logic        in_last_byte,
  input logic        in_empty_token,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_reason,
  input logic [32:0] out_value_out,
  input logic [6:0]  out_error_offset
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reason) && $stable(out_value_out)
      && $stable(out_error_offset))
    else $error("stalled transaction changed");

  // overflow faults reuse below/above with the offending byte's offset
  a_range_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reason == RSN_OK || out_reason == RSN_SHORT || out_reason == RSN_LONG)
      |-> out_error_offset == 7'd0)
    else $error("nonzero offset on ok or length verdict");

  a_length_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reason == RSN_SHORT || out_reason == RSN_LONG)
      |-> out_value_out[32:7] == 26'd0)
    else $error("length verdict value exceeds 7 bits");

  a_reason_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reason != 3'd7)
    else $error("undefined reason code");

endmodule

bind typed_token_value_checker ttvc_checker u_ttvc_checker (.*);

@@ test/tb_typed_token_value_checker.sv @@
// tb_typed_token_value_checker: self-checking testbench for the typed token value checker.
// Drives tokens byte by byte with random idling on both channels and checks every verdict
// against an in-bench predictor. Depends on ttvc_pkg and typed_token_value_checker.
`timescale 1ns / 1ps

module tb_typed_token_value_checker;
  import ttvc_pkg::*;

  typedef logic [7:0] tok_bytes_t [$];

  localparam int POS_CAP = (MAX_TOKEN_BYTES_DEF < 127) ? MAX_TOKEN_BYTES_DEF : 127;
  localparam int RANDOM_ITEMS = 1250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [32:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_token_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        in_empty_token = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_reason;
  logic [32:0] out_value_out;
  logic [6:0]  out_error_offset;

  typed_token_value_checker dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_token_byte   (in_token_byte),
    .in_last_byte    (in_last_byte),
    .in_empty_token  (in_empty_token),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reason      (out_reason),
    .out_value_out   (out_value_out),
    .out_error_offset(out_error_offset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers
  kind_t              cf_kind = KIND_SIGNED;
  logic signed [32:0] cf_min = MIN_VALUE_RST;
  logic signed [32:0] cf_max = MAX_VALUE_RST;
  logic [6:0]         cf_min_len = MIN_LEN_RST;
  logic [6:0]         cf_max_len = MAX_LEN_RST;

  // predictor copy of the per-token state
  logic [6:0]  tk_pos = '0;
  logic [31:0] tk_mag = '0;
  logic        tk_neg = 1'b0;
  reason_t     tk_fault = RSN_OK;
  logic [6:0]  tk_fault_at = '0;
  logic [5:0]  tk_spell = 6'h3F;
  logic        tk_over = 1'b0;

  string spell_word [6] = '{"on", "true", "1", "off", "false", "0"};

  verdict_t verdict_q [$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       stall_left = 0;
  bit       send_lazy = 1'b1;
  bit       recv_lazy = 1'b1;

  function automatic void clear_token();
    tk_pos = '0;
    tk_mag = '0;
    tk_neg = 1'b0;
    tk_fault = RSN_OK;
    tk_fault_at = '0;
    tk_spell = 6'h3F;
    tk_over = 1'b0;
  endfunction

  function automatic void take_digit(logic [7:0] b, logic [6:0] idx,
                                     longint unsigned limit, reason_t over_rsn);
    longint unsigned t;
    if (b == 8'h00) begin
      tk_fault = RSN_NUL;
      tk_fault_at = idx;
    end else if (b < "0" || b > "9") begin
      tk_fault = RSN_INVALID;
      tk_fault_at = idx;
    end else begin
      t = longint'(tk_mag) * 10 + longint'(b - 8'd48);
      if (t > limit) begin
        tk_fault = over_rsn;
        tk_fault_at = idx;
      end else begin
        tk_mag = t[31:0];
      end
    end
  endfunction

  function automatic void judge_byte(logic [7:0] b);
    logic [6:0] idx;
    logic [7:0] lw;
    idx = tk_pos;
    lw = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    if (tk_pos >= POS_CAP) tk_over = 1'b1;
    else tk_pos = tk_pos + 7'd1;
    for (int s = 0; s < 6; s++) begin
      if (tk_spell[s] && (idx >= spell_word[s].len() || lw != spell_word[s][idx])) begin
        tk_spell[s] = 1'b0;
      end
    end
    if (tk_fault != RSN_OK) return;
    case (cf_kind)
      KIND_SIGNED: begin
        if (idx == 0 && b == "+") begin
          tk_fault = RSN_INVALID;
          tk_fault_at = '0;
        end else if (idx == 0 && b == "-") begin
          tk_neg = 1'b1;
        end else begin
          take_digit(b, idx, tk_neg ? 64'd2147483648 : 64'd2147483647,
                     tk_neg ? RSN_BELOW : RSN_ABOVE);
        end
      end
      KIND_UNSIGNED: take_digit(b, idx, 64'hFFFF_FFFF, RSN_ABOVE);
      default: begin
        if (b == 8'h00) begin
          tk_fault = RSN_NUL;
          tk_fault_at = idx;
        end
      end
    endcase
  endfunction

  function automatic reason_t bound_check(logic signed [32:0] v);
    if (v < cf_min) return RSN_BELOW;
    if (v > cf_max) return RSN_ABOVE;
    return RSN_OK;
  endfunction

  function automatic void close_token();
    verdict_t v;
    bit       hit;
    v.reason = RSN_OK;
    v.value = '0;
    v.offset = '0;
    hit = 1'b0;
    if (tk_fault != RSN_OK) begin
      v.reason = tk_fault;
      v.offset = tk_fault_at;
      if (cf_kind == KIND_TEXT) v.value = {26'd0, tk_pos};
    end else begin
      case (cf_kind)
        KIND_SIGNED: begin
          if (tk_pos == 0 || (tk_neg && tk_pos == 1)) begin
            v.reason = RSN_INVALID;
          end else begin
            v.value = tk_neg ? -$signed({1'b0, tk_mag}) : {1'b0, tk_mag};
            v.reason = bound_check($signed(v.value));
          end
        end
        KIND_UNSIGNED: begin
          if (tk_pos == 0) begin
            v.reason = RSN_INVALID;
          end else begin
            v.value = {1'b0, tk_mag};
            v.reason = bound_check($signed(v.value));
          end
        end
        KIND_BOOL: begin
          v.reason = RSN_INVALID;
          for (int s = 0; s < 6; s++) begin
            if (!hit && tk_spell[s] && tk_pos == spell_word[s].len()) begin
              hit = 1'b1;
              v.reason = RSN_OK;
              v.value = (s < 3) ? 33'd1 : 33'd0;
            end
          end
        end
        default: begin
          v.value = {26'd0, tk_pos};
          if (!tk_over && tk_pos < cf_min_len) v.reason = RSN_SHORT;
          else if (tk_over || tk_pos > cf_max_len) v.reason = RSN_LONG;
        end
      endcase
      if (v.reason != RSN_OK && cf_kind != KIND_TEXT) v.value = '0;
    end
    verdict_q.push_back(v);
    clear_token();
  endfunction

  function automatic void predict_item(logic [7:0] b, logic last, logic empty);
    if (!empty) begin
      judge_byte(b);
      if (!last) return;
    end
    close_token();
  endfunction

  task automatic report_error(input string msg);
    if (n_errors < 40) $display("%0t ns: mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // result side: check each accepted transaction, then draw the next stall
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report_error("verdict with none pending");
      end else begin
        want = verdict_q.pop_front();
        if (out_reason !== want.reason)
          report_error($sformatf("reason got %0d want %0d", out_reason, want.reason));
        if (out_value_out !== want.value)
          report_error($sformatf("value got %0d want %0d",
                                 $signed(out_value_out), $signed(want.value)));
        if (out_error_offset !== want.offset)
          report_error($sformatf("offset got %0d want %0d", out_error_offset, want.offset));
      end
      stall_left = recv_lazy ? $urandom_range(0, 19) : 0;
      if ($urandom_range(0, 49) == 0) recv_lazy = !recv_lazy;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = recv_lazy && ($urandom_range(0, 3) == 0);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last, input logic empty);
    int gap;
    gap = send_lazy ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_token_byte = b;
    in_last_byte = last;
    in_empty_token = empty;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(b, last, empty);
    n_sent++;
    if ($urandom_range(0, 39) == 0) send_lazy = !send_lazy;
    @(negedge clk);
  endtask

  task automatic send_token(input tok_bytes_t tok, input bit end_mark);
    int n;
    n = tok.size();
    for (int i = 0; i < n; i++) push_byte(tok[i], (i == n - 1) && !end_mark, 1'b0);
    if (end_mark || n == 0) push_byte(8'($urandom), 1'($urandom), 1'b1);
  endtask

  // sender holds off until every pending verdict is out and the pipeline is empty
  task automatic settle();
    in_valid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [32:0] data);
    cfg_index = idx;
    cfg_wdata = data;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_ARG_KIND:  cf_kind = kind_t'(data[1:0]);
      CFG_MIN_VALUE: cf_min = $signed(data);
      CFG_MAX_VALUE: cf_max = $signed(data);
      CFG_MIN_LEN:   cf_min_len = data[6:0];
      CFG_MAX_LEN:   cf_max_len = data[6:0];
      default: ;
    endcase
  endtask

  function automatic tok_bytes_t str_bytes(string s);
    tok_bytes_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic tok_bytes_t make_number(bit signed_kind);
    tok_bytes_t      t;
    longint unsigned mag;
    string           digits;
    case ($urandom_range(0, 9))
      0: mag = 0;
      1: mag = 64'd2147483647 + $urandom_range(0, 1);
      2: mag = 64'd2147483648 + $urandom_range(0, 1);
      3: mag = 64'd4294967295;
      4: mag = 64'd4294967296 + $urandom_range(0, 5);
      5: mag = longint'($urandom) * 10 + $urandom_range(0, 9);
      6: mag = 64'($urandom_range(0, 99));
      default: mag = 64'($urandom);
    endcase
    if (signed_kind && $urandom_range(0, 9) < 4) t.push_back("-");
    else if ($urandom_range(0, 29) == 0) t.push_back("+");
    else if (!signed_kind && $urandom_range(0, 19) == 0) t.push_back("-");
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) t.push_back("0");
    digits = $sformatf("%0d", mag);
    for (int i = 0; i < digits.len(); i++) t.push_back(digits[i]);
    return t;
  endfunction

  function automatic tok_bytes_t make_bool();
    tok_bytes_t t;
    string      w;
    logic [7:0] c;
    w = spell_word[$urandom_range(0, 5)];
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      t.push_back(c);
    end
    case ($urandom_range(0, 9))
      0: if (t.size() > 1) void'(t.pop_back());
      1: t.push_back(8'($urandom_range(0, 255)));
      2: t.push_front(8'($urandom_range(0, 255)));
      default: ;
    endcase
    return t;
  endfunction

  function automatic tok_bytes_t make_text();
    tok_bytes_t t;
    int         n;
    case ($urandom_range(0, 9))
      0: n = $urandom_range(64, 70);
      1, 2: n = $urandom_range(13, 64);
      default: n = $urandom_range(0, 12);
    endcase
    repeat (n) t.push_back(($urandom_range(0, 39) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    return t;
  endfunction

  function automatic tok_bytes_t make_noise();
    tok_bytes_t t;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 3))
        0: t.push_back(8'h00);
        1: t.push_back($urandom_range(0, 1) ? "+" : "-");
        default: t.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    return t;
  endfunction

  function automatic longint pick_bound();
    case ($urandom_range(0, 7))
      0: return -64'sd2147483648;
      1: return 64'sd4294967295;
      2: return 64'sd2147483647;
      3: return 0;
      4: return longint'($urandom_range(0, 200)) - 100;
      5: return longint'($urandom);
      6: return -longint'($urandom_range(0, 2147483647)) - 1;
      default: return 64'sd2147483648;
    endcase
  endfunction

  task automatic test_sign_rules();
    send_token(str_bytes("+7"), 1'b0);
    send_token(str_bytes("-"), 1'b0);
    send_token(str_bytes("-12"), 1'b0);
  endtask

  task automatic test_empty_and_nul();
    tok_bytes_t tok;
    send_token(tok, 1'b0);
    tok = str_bytes("5");
    tok.push_back(8'h00);
    send_token(tok, 1'b0);
    tok = {8'hFF};
    send_token(tok, 1'b0);
  endtask

  task automatic test_bool_spellings();
    settle();
    write_reg(CFG_ARG_KIND, 33'(KIND_BOOL));
    send_token(str_bytes("TrUe"), 1'b0);
    send_token(str_bytes("0"), 1'b0);
    send_token(str_bytes("of"), 1'b1);
  endtask

  task automatic test_text_bounds();
    tok_bytes_t tok;
    settle();
    write_reg(CFG_ARG_KIND, 33'(KIND_TEXT));
    write_reg(CFG_MIN_LEN, 33'd2);
    write_reg(CFG_MAX_LEN, 33'd3);
    send_token(str_bytes("a"), 1'b0);
    send_token(tok, 1'b0);
  endtask

  // first byte judged as signed, last byte and verdict as text
  task automatic test_kind_switch_mid_token();
    settle();
    write_reg(CFG_ARG_KIND, 33'(KIND_SIGNED));
    push_byte("7", 1'b0, 1'b0);
    settle();
    write_reg(CFG_ARG_KIND, 33'(KIND_TEXT));
    push_byte("x", 1'b1, 1'b0);
  endtask

  task automatic test_random_tokens();
    kind_t      kind;
    longint     lo;
    longint     hi;
    tok_bytes_t tok;
    int         target;
    target = n_sent + RANDOM_ITEMS;
    while (n_sent < target) begin
      settle();
      kind = kind_t'($urandom_range(0, 3));
      lo = pick_bound();
      hi = pick_bound();
      write_reg(CFG_ARG_KIND, 33'(kind));
      write_reg(CFG_MIN_VALUE, lo[32:0]);
      write_reg(CFG_MAX_VALUE, hi[32:0]);
      case ($urandom_range(0, 3))
        0: write_reg(CFG_MIN_LEN, 33'd0);
        1: write_reg(CFG_MIN_LEN, 33'd64);
        default: write_reg(CFG_MIN_LEN, 33'($urandom_range(0, 16)));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_MAX_LEN, 33'd64);
        1: write_reg(CFG_MAX_LEN, 33'd0);
        default: write_reg(CFG_MAX_LEN, 33'($urandom_range(0, 20)));
      endcase
      repeat ($urandom_range(5, 30)) begin
        tok.delete();
        if ($urandom_range(0, 3) != 0) begin
          case (kind)
            KIND_SIGNED:   tok = make_number(1'b1);
            KIND_UNSIGNED: tok = make_number(1'b0);
            KIND_BOOL:     tok = make_bool();
            default:       tok = make_text();
          endcase
        end else if ($urandom_range(0, 4) != 0) begin
          tok = make_noise();
        end
        send_token(tok, $urandom_range(0, 9) == 0);
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    clear_token();
    test_sign_rules();
    test_empty_and_nul();
    test_bool_spellings();
    test_text_bounds();
    test_kind_switch_mid_token();
    test_random_tokens();
    settle();
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ttvc_pkg.sv
rtl/ttvc_step.sv
rtl/typed_token_value_checker.sv
rtl/ttvc_checker.sv
test/tb_typed_token_value_checker.sv
